// ----- src/itag_pkg.sv -----
// Shared types and constants of the im2col tap address generator.
// Holds the register map, the controller states and the controller/datapath interface.
// Depends on nothing; every other file of the block imports it.
package itag_pkg;

	localparam int POS_W  = 20;
	localparam int CFG_W  = 11;
	localparam int IDX_W  = 4;
	localparam int KDIM_W = 4;
	localparam int PAD_W  = 3;
	localparam int SRC_W  = 30;
	localparam int DST_W  = 16;

	localparam int STRIDE_H_DEF   = 1;
	localparam int STRIDE_W_DEF   = 1;
	localparam int MAX_KERNEL_DEF = 8;

	typedef enum logic [IDX_W-1:0] {
		REG_IN_HEIGHT = 4'd0,
		REG_IN_WIDTH  = 4'd1,
		REG_CHANNELS  = 4'd2,
		REG_KERNEL_H  = 4'd3,
		REG_KERNEL_W  = 4'd4,
		REG_PAD_TOP   = 4'd5,
		REG_LEFT_PAD  = 4'd6,
		REG_OUT_WIDTH = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0]  in_height;
		logic [CFG_W-1:0]  in_width;
		logic [CFG_W-1:0]  channels;
		logic [KDIM_W-1:0] kernel_h;
		logic [KDIM_W-1:0] kernel_w;
		logic [PAD_W-1:0]  pad_top;
		logic [PAD_W-1:0]  left_pad;
		logic [CFG_W-1:0]  out_width;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ORIGIN,
		ST_ROW,
		ST_BASE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic div_start;
		logic div_step;
		logic origin_calc;
		logic row_calc;
		logic base_calc;
		logic tap_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic kernel_zero;
		logic tap_last;
		logic out_free;
	} status_t;

endpackage

// ----- src/itag_cfg.sv -----
// Configuration register file of the im2col tap address generator.
// Depends on itag_pkg for the register map and the cfg_t bundle.
module itag_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [itag_pkg::IDX_W-1:0]   cfg_index,
	input  logic [itag_pkg::CFG_W-1:0]   cfg_data,
	output itag_pkg::cfg_t               cfg
);
	import itag_pkg::*;

	cfg_t cfg_q;

	// Writes are always taken; indexes beyond the map fall into the default arm.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_height <= CFG_W'(1);
			cfg_q.in_width  <= CFG_W'(1);
			cfg_q.channels  <= CFG_W'(1);
			cfg_q.kernel_h  <= KDIM_W'(1);
			cfg_q.kernel_w  <= KDIM_W'(1);
			cfg_q.pad_top   <= '0;
			cfg_q.left_pad  <= '0;
			cfg_q.out_width <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_IN_HEIGHT: cfg_q.in_height <= cfg_data;
				REG_IN_WIDTH:  cfg_q.in_width  <= cfg_data;
				REG_CHANNELS:  cfg_q.channels  <= cfg_data;
				REG_KERNEL_H:  cfg_q.kernel_h  <= cfg_data[KDIM_W-1:0];
				REG_KERNEL_W:  cfg_q.kernel_w  <= cfg_data[KDIM_W-1:0];
				REG_PAD_TOP:   cfg_q.pad_top   <= cfg_data[PAD_W-1:0];
				REG_LEFT_PAD:  cfg_q.left_pad  <= cfg_data[PAD_W-1:0];
				REG_OUT_WIDTH: cfg_q.out_width <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- src/itag_ctrl.sv -----
// Sequencing state machine of the im2col tap address generator.
// Depends on itag_pkg for state_t, cmd_t and status_t.
module itag_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  itag_pkg::status_t   status,
	output itag_pkg::cmd_t      cmd
);
	import itag_pkg::*;

	state_t state_q;
	state_t state_next;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_next = ST_ORIGIN;
				end
			end
			ST_ORIGIN: begin
				state_next = ST_ROW;
			end
			ST_ROW: begin
				state_next = ST_BASE;
			end
			ST_BASE: begin
				state_next = status.kernel_zero ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free && status.tap_last) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall      = 1'b0;
				cmd.div_start = in_valid;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_ORIGIN: begin
				cmd.origin_calc = 1'b1;
			end
			ST_ROW: begin
				cmd.row_calc = 1'b1;
			end
			ST_BASE: begin
				cmd.base_calc = 1'b1;
			end
			ST_EMIT: begin
				cmd.tap_load = status.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// ----- src/itag_dp.sv -----
// Datapath of the im2col tap address generator: bit-serial divider, origin and
// base-address arithmetic, incremental tap walker and the output register.
// Depends on itag_pkg for cfg_t, cmd_t, status_t and field widths.
module itag_dp #(
	parameter int STRIDE_H   = itag_pkg::STRIDE_H_DEF,
	parameter int STRIDE_W   = itag_pkg::STRIDE_W_DEF,
	parameter int MAX_KERNEL = itag_pkg::MAX_KERNEL_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  itag_pkg::cfg_t               cfg,
	input  logic [itag_pkg::POS_W-1:0]   position,
	input  itag_pkg::cmd_t               cmd,
	output itag_pkg::status_t            status,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [itag_pkg::SRC_W-1:0]   src_offset,
	output logic [itag_pkg::DST_W-1:0]   dst_offset,
	output logic                         is_padding,
	output logic                         last
);
	import itag_pkg::*;

	localparam int SH_W   = $clog2(STRIDE_H + 1);
	localparam int SW_W   = $clog2(STRIDE_W + 1);
	localparam int RW     = POS_W + SH_W + 1;
	localparam int CW     = CFG_W + SW_W + 1;
	localparam int KCW    = $clog2(MAX_KERNEL + 1);
	localparam int DCNT_W = $clog2(POS_W);

	// Divider registers: the dividend shifts out at the top while quotient bits enter below.
	logic [POS_W-1:0]  quo_q;
	logic [CFG_W-1:0]  rem_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic [CFG_W-1:0]  ow_eff;
	logic [CFG_W:0]    trial;
	logic              trial_ge;

	// Origin and base-address registers.
	logic signed [RW-1:0] r0_q;
	logic signed [CW-1:0] c0_q;
	logic [SRC_W-1:0]     wc_q;
	logic [SRC_W-1:0]     t1_q;

	logic [RW-2:0]        row_scaled;
	logic [CW-2:0]        col_scaled;
	logic [SRC_W-1:0]     r0_ext;
	logic [SRC_W-1:0]     c0_ext;

	// Tap walker registers.
	logic [KCW-1:0]       p_q;
	logic [KCW-1:0]       q_q;
	logic signed [RW-1:0] rcur_q;
	logic signed [CW-1:0] ccur_q;
	logic [SRC_W-1:0]     row_base_q;
	logic [SRC_W-1:0]     addr_q;
	logic [DST_W-1:0]     dst_q;

	logic [KCW-1:0]       kh_eff;
	logic [KCW-1:0]       kw_eff;
	logic                 col_last;
	logic                 row_last;
	logic                 tap_pad;

	logic                 out_valid_q;
	logic [SRC_W-1:0]     src_q;
	logic [DST_W-1:0]     dst_out_q;
	logic                 pad_q;
	logic                 last_q;

	assign ow_eff   = (cfg.out_width == '0) ? CFG_W'(1) : cfg.out_width;
	assign trial    = {rem_q, quo_q[POS_W-1]};
	assign trial_ge = (trial >= {1'b0, ow_eff});

	assign row_scaled = (RW-1)'(quo_q) * (RW-1)'(STRIDE_H);
	assign col_scaled = (CW-1)'(rem_q) * (CW-1)'(STRIDE_W);
	assign r0_ext     = {{(SRC_W-RW){r0_q[RW-1]}}, r0_q};
	assign c0_ext     = {{(SRC_W-CW){c0_q[CW-1]}}, c0_q};

	assign kh_eff = (cfg.kernel_h > KDIM_W'(MAX_KERNEL)) ? KCW'(MAX_KERNEL)
	                                                     : KCW'(cfg.kernel_h);
	assign kw_eff = (cfg.kernel_w > KDIM_W'(MAX_KERNEL)) ? KCW'(MAX_KERNEL)
	                                                     : KCW'(cfg.kernel_w);
	assign col_last = (q_q == kw_eff - KCW'(1));
	assign row_last = (p_q == kh_eff - KCW'(1));

	// A tap is padding when its source row or column is negative or past the input edge.
	assign tap_pad = rcur_q[RW-1] || ccur_q[CW-1]
	                 || (rcur_q[RW-2:0] >= (RW-1)'(cfg.in_height))
	                 || (ccur_q[CW-2:0] >= (CW-1)'(cfg.in_width));

	assign status.div_done    = (dcnt_q == DCNT_W'(POS_W - 1));
	assign status.kernel_zero = (kh_eff == '0) || (kw_eff == '0);
	assign status.tap_last    = row_last && col_last;
	assign status.out_free    = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q  <= position;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q  <= {quo_q[POS_W-2:0], trial_ge};
			rem_q  <= trial_ge ? CFG_W'(trial - {1'b0, ow_eff}) : trial[CFG_W-1:0];
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.origin_calc) begin
			r0_q <= $signed({1'b0, row_scaled}) - $signed({{(RW-PAD_W){1'b0}}, cfg.pad_top});
			c0_q <= $signed({1'b0, col_scaled}) - $signed({{(CW-PAD_W){1'b0}}, cfg.left_pad});
			wc_q <= SRC_W'(SRC_W'(cfg.in_width) * SRC_W'(cfg.channels));
		end
		if (cmd.row_calc) begin
			t1_q <= SRC_W'(r0_ext * SRC_W'(cfg.in_width)) + c0_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.base_calc) begin
			p_q        <= '0;
			q_q        <= '0;
			rcur_q     <= r0_q;
			ccur_q     <= c0_q;
			row_base_q <= SRC_W'(t1_q * SRC_W'(cfg.channels));
			addr_q     <= SRC_W'(t1_q * SRC_W'(cfg.channels));
			dst_q      <= '0;
		end else if (cmd.tap_load) begin
			dst_q <= dst_q + DST_W'(cfg.channels);
			if (col_last) begin
				p_q        <= p_q + KCW'(1);
				q_q        <= '0;
				rcur_q     <= rcur_q + RW'(1);
				ccur_q     <= c0_q;
				row_base_q <= row_base_q + wc_q;
				addr_q     <= row_base_q + wc_q;
			end else begin
				q_q    <= q_q + KCW'(1);
				ccur_q <= ccur_q + CW'(1);
				addr_q <= addr_q + SRC_W'(cfg.channels);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.tap_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tap_load) begin
			src_q     <= tap_pad ? '0 : addr_q;
			dst_out_q <= dst_q;
			pad_q     <= tap_pad;
			last_q    <= row_last && col_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign src_offset = src_q;
	assign dst_offset = dst_out_q;
	assign is_padding = pad_q;
	assign last       = last_q;

endmodule

// ----- src/im2col_tap_address_generator_top.sv -----
// Top level of the im2col tap address generator.
// Instantiates itag_cfg, itag_ctrl and itag_dp; depends on itag_pkg.
//
// Usage: software programs the geometry through the configuration channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data) while the block is idle; cfg_ready
// is always high, and an index beyond the register map is dropped. Each input
// beat (in_valid/in_stall, position) names one linear output position. The block
// splits it into output row and column, then sends one output beat per kernel tap,
// tap row outer and tap column inner, with the HWC source offset, the offset in
// the im2col column, a padding flag and a last flag on the final tap.
// Sequence: a position first passes through the bit-serial divider, which yields
// one quotient bit per cycle over the 20-bit position; the ORIGIN, ROW and BASE
// states then form the origin, row product and base address, and the tap walker
// yields one beat per cycle while out_stall does not hold it. The first tap is
// loaded into the output register from the EMIT state that follows BASE. While
// an item is in flight in_stall stays high. When out_stall is high the held beat
// stays unchanged and the tap walker waits. The next position can be taken while
// the last tap of the previous one is still waiting in the output register.
// Reset (arst_n low) clears the state machine and the output valid, and loads
// every configuration register with its reset value.
module im2col_tap_address_generator_top #(
	parameter int STRIDE_H   = itag_pkg::STRIDE_H_DEF,
	parameter int STRIDE_W   = itag_pkg::STRIDE_W_DEF,
	parameter int MAX_KERNEL = itag_pkg::MAX_KERNEL_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [itag_pkg::IDX_W-1:0]   cfg_index,
	input  logic [itag_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [itag_pkg::POS_W-1:0]   position,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [itag_pkg::SRC_W-1:0]   src_offset,
	output logic [itag_pkg::DST_W-1:0]   dst_offset,
	output logic                         is_padding,
	output logic                         last
);
	import itag_pkg::*;

	// Register bundle, commands from the controller and status back to it.
	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	itag_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The controller only sequences; it never touches payload.
	itag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the divider, address arithmetic and output register.
	itag_dp #(
		.STRIDE_H   (STRIDE_H),
		.STRIDE_W   (STRIDE_W),
		.MAX_KERNEL (MAX_KERNEL)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.position   (position),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.src_offset (src_offset),
		.dst_offset (dst_offset),
		.is_padding (is_padding),
		.last       (last)
	);

endmodule
